// ----- rtl/kdq_pkg.sv -----
package kdq_pkg;

   localparam int KDQ_CAPACITY = 16;
   localparam int WORD_W       = 32;

   // operation codes
   localparam logic [1:0] OP_PUSH_REAR  = 2'd0;
   localparam logic [1:0] OP_POP_FRONT  = 2'd1;
   localparam logic [1:0] OP_PUSH_FRONT = 2'd2;
   localparam logic [1:0] OP_POP_REAR   = 2'd3;

   // status codes
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_DUP   = 2'd1;
   localparam logic [1:0] STAT_FULL  = 2'd2;
   localparam logic [1:0] STAT_EMPTY = 2'd3;

   localparam logic signed [WORD_W-1:0] NEG_ONE = '1;

   typedef struct packed {
      logic [1:0]               operation;
      logic signed [WORD_W-1:0] item_key;
      logic signed [WORD_W-1:0] item_value;
   } req_type;

   typedef struct packed {
      logic [1:0]               status;
      logic signed [WORD_W-1:0] popped_value;
   } rsp_type;

endpackage

// ----- rtl/keyed_double_ended_queue_unit.sv -----
// Keyed double-ended queue: up to Capacity key/data pairs in a ring of two RAMs, with push
// and pop at both ends. A push first reads every live key, one per cycle through a single
// RAM port and one comparator, and is refused with a duplicate status on any match, or
// with a full status when no slot is left. A pop reads the value RAM and answers from
// the pop state, and a pop from an empty queue answers without a RAM read, with status
// empty and data -1.
// One transaction is in flight at a time; req_ready drops from acceptance until the result
// has been taken. Stores need no clearing after reset.
module keyed_double_ended_queue_unit #(
   parameter int Capacity = kdq_pkg::KDQ_CAPACITY
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  kdq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output kdq_pkg::rsp_type rsp_data
);

   import kdq_pkg::*;

   localparam int PtrW = $clog2(Capacity);
   localparam int CntW = $clog2(Capacity + 1);
   localparam logic [CntW-1:0] CapCnt  = CntW'(Capacity);
   localparam logic [PtrW:0]   CapWide = (PtrW + 1)'(Capacity);
   localparam logic [PtrW-1:0] LastPos = PtrW'(Capacity - 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_POP  = 2'd2;

   function automatic logic [PtrW-1:0] ring_add(input logic [PtrW-1:0] a,
                                                input logic [PtrW-1:0] b);
      logic [PtrW:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum >= CapWide) begin
         sum = sum - CapWide;
      end
      return sum[PtrW-1:0];
   endfunction

   logic [1:0]      state_ff, state_in;
   req_type         req_ff, req_in;
   logic [PtrW-1:0] head_ff, head_in;
   logic [CntW-1:0] count_ff, count_in;
   logic [PtrW-1:0] scan_pos_ff, scan_pos_in;
   logic [CntW-1:0] scan_left_ff, scan_left_in;
   logic            rd_pend_ff, rd_pend_in;
   logic            dup_ff, dup_in;
   rsp_type         rsp_ff, rsp_in;
   logic            rsp_valid_ff, rsp_valid_in;

   logic              key_rd_en, val_rd_en, wr_en;
   logic [PtrW-1:0]   val_rd_addr, wr_addr, head_dec;
   logic [WORD_W-1:0] key_rdata, val_rdata;
   logic              dup_now, scan_done, accept, is_push;

   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign accept    = req_valid && req_ready;
   assign is_push   = (req_data.operation == OP_PUSH_REAR) ||
                      (req_data.operation == OP_PUSH_FRONT);
   assign head_dec  = (head_ff == '0) ? LastPos : head_ff - PtrW'(1);
   assign key_rd_en = (state_ff == S_SCAN) && (scan_left_ff != '0);
   assign dup_now   = dup_ff ||
                      (rd_pend_ff && (key_rdata == $unsigned(req_ff.item_key)));
   assign scan_done = (scan_left_ff == '0) && !rd_pend_ff;
   assign wr_addr   = (req_ff.operation == OP_PUSH_REAR) ?
                      ring_add(head_ff, count_ff[PtrW-1:0]) : head_dec;

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      scan_pos_in  = scan_pos_ff;
      scan_left_in = scan_left_ff;
      rd_pend_in   = 1'b0;
      dup_in       = dup_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      val_rd_en    = 1'b0;
      val_rd_addr  = head_ff;
      wr_en        = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_in = req_data;
               if (is_push) begin
                  scan_pos_in  = head_ff;
                  scan_left_in = count_ff;
                  dup_in       = 1'b0;
                  state_in     = S_SCAN;
               end else if (count_ff == '0) begin
                  rsp_in.status       = STAT_EMPTY;
                  rsp_in.popped_value = NEG_ONE;
                  rsp_valid_in        = 1'b1;
               end else begin
                  val_rd_en = 1'b1;
                  count_in  = count_ff - CntW'(1);
                  if (req_data.operation == OP_POP_FRONT) begin
                     val_rd_addr = head_ff;
                     head_in     = ring_add(head_ff, PtrW'(1));
                  end else begin
                     val_rd_addr = ring_add(head_ff, count_in[PtrW-1:0]);
                  end
                  state_in = S_POP;
               end
            end
         end
         S_SCAN: begin
            dup_in = dup_now;
            // issue one key read per cycle, compare it on the next
            if (scan_left_ff != '0) begin
               rd_pend_in   = 1'b1;
               scan_left_in = scan_left_ff - CntW'(1);
               scan_pos_in  = ring_add(scan_pos_ff, PtrW'(1));
            end
            if (scan_done) begin
               rsp_in.popped_value = NEG_ONE;
               rsp_valid_in        = 1'b1;
               state_in            = S_IDLE;
               if (dup_now) begin
                  rsp_in.status = STAT_DUP;
               end else if (count_ff == CapCnt) begin
                  rsp_in.status = STAT_FULL;
               end else begin
                  rsp_in.status = STAT_OK;
                  wr_en         = 1'b1;
                  count_in      = count_ff + CntW'(1);
                  if (req_ff.operation == OP_PUSH_FRONT) begin
                     head_in = head_dec;
                  end
               end
            end
         end
         S_POP: begin
            rsp_in.status       = STAT_OK;
            rsp_in.popped_value = $signed(val_rdata);
            rsp_valid_in        = 1'b1;
            state_in            = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rd_pend_ff   <= 1'b0;
         dup_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rd_pend_ff   <= rd_pend_in;
         dup_ff       <= dup_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff       <= req_in;
      scan_pos_ff  <= scan_pos_in;
      scan_left_ff <= scan_left_in;
      rsp_ff       <= rsp_in;
   end

   kdq_ram #(
      .Width(WORD_W),
      .Depth(Capacity)
   ) u_key_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data($unsigned(req_ff.item_key)),
      .rd_en  (key_rd_en),
      .rd_addr(scan_pos_ff),
      .rd_data(key_rdata)
   );

   kdq_ram #(
      .Width(WORD_W),
      .Depth(Capacity)
   ) u_val_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data($unsigned(req_ff.item_value)),
      .rd_en  (val_rd_en),
      .rd_addr(val_rd_addr),
      .rd_data(val_rdata)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CapCnt)
      else $error("entry count exceeds capacity");

   a_no_result_while_scanning: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) || (state_ff == S_POP) |-> !rsp_valid_ff)
      else $error("result pending while a transaction is in progress");

   a_pop_shrinks: assert property (@(posedge clock) disable iff (reset)
      accept && !is_push && (count_ff != '0) |=> count_ff == $past(count_ff) - CntW'(1))
      else $error("pop did not remove an entry");

   a_scan_ends_in_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) && scan_done |=> rsp_valid_ff && (state_ff == S_IDLE))
      else $error("finished key scan gave no result");

endmodule

// ----- rtl/kdq_ram.sv -----
module kdq_ram #(
   parameter int Width = 32,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- tb/sv/kdq_scoreboard.sv -----
`timescale 1ns / 1ps

module kdq_scoreboard
   import kdq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      outstanding,
   output int      dup_seen,
   output int      full_seen,
   output int      empty_seen
);

   logic [WORD_W-1:0] key_ring [KDQ_CAPACITY];
   logic [WORD_W-1:0] value_ring [KDQ_CAPACITY];
   int                front_pos;
   int                live_count;
   rsp_type           awaited_q [$];
   rsp_type           want;

   // Apply one transaction to the shadow deque and return the response it must produce.
   function automatic rsp_type advance_deque(req_type r);
      rsp_type res;
      bit      hit;
      int      slot;
      res.status       = STAT_OK;
      res.popped_value = NEG_ONE;
      case (r.operation)
         OP_PUSH_REAR, OP_PUSH_FRONT: begin
            hit = 1'b0;
            for (int i = 0; i < live_count; i++) begin
               if (key_ring[(front_pos + i) % KDQ_CAPACITY] == r.item_key) hit = 1'b1;
            end
            // duplicate wins over full
            if (hit) begin
               res.status = STAT_DUP;
            end else if (live_count >= KDQ_CAPACITY) begin
               res.status = STAT_FULL;
            end else begin
               if (r.operation == OP_PUSH_REAR) begin
                  slot = (front_pos + live_count) % KDQ_CAPACITY;
               end else begin
                  front_pos = (front_pos + KDQ_CAPACITY - 1) % KDQ_CAPACITY;
                  slot      = front_pos;
               end
               key_ring[slot]   = r.item_key;
               value_ring[slot] = r.item_value;
               live_count++;
            end
         end
         default: begin
            if (live_count == 0) begin
               res.status = STAT_EMPTY;
            end else if (r.operation == OP_POP_FRONT) begin
               res.popped_value = value_ring[front_pos];
               front_pos        = (front_pos + 1) % KDQ_CAPACITY;
               live_count--;
            end else begin
               res.popped_value = value_ring[(front_pos + live_count - 1) % KDQ_CAPACITY];
               live_count--;
            end
         end
      endcase
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         front_pos  = 0;
         live_count = 0;
         awaited_q.delete();
         outstanding <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_q.size() == 0) begin
               $error("unexpected response: status %0d popped_value %h",
                      rsp_data.status, rsp_data.popped_value);
               fail_count++;
            end else begin
               want = awaited_q.pop_front();
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_data.status);
                  fail_count++;
               end
               if (rsp_data.popped_value !== want.popped_value) begin
                  $error("popped_value: expected %h, actual %h",
                         want.popped_value, rsp_data.popped_value);
                  fail_count++;
               end
               case (want.status)
                  STAT_DUP:   dup_seen++;
                  STAT_FULL:  full_seen++;
                  STAT_EMPTY: empty_seen++;
                  default:    ;
               endcase
            end
         end
         if (req_valid && req_ready) awaited_q.push_back(advance_deque(req_data));
         outstanding <= awaited_q.size();
      end
   end

endmodule

// ----- tb/sv/tb_keyed_double_ended_queue_unit.sv -----
`timescale 1ns / 1ps

module tb_keyed_double_ended_queue_unit;
   import kdq_pkg::*;

   localparam int RANDOM_ITEMS = 500;
   localparam int POOL_SIZE    = 24;
   localparam int CYCLE_LIMIT  = 400000;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int fail_count, outstanding, dup_seen, full_seen, empty_seen;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int cycle_count   = 0;
   int pushes_sent   = 0;
   int pops_sent     = 0;
   int push_bias     = 70;

   logic [WORD_W-1:0] key_pool [POOL_SIZE];

   keyed_double_ended_queue_unit u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   kdq_scoreboard u_scoreboard (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .fail_count (fail_count),
      .outstanding(outstanding),
      .dup_seen   (dup_seen),
      .full_seen  (full_seen),
      .empty_seen (empty_seen)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic send_item(input logic [1:0] op, input logic [WORD_W-1:0] k,
                            input logic [WORD_W-1:0] v);
      req_type r;
      r.operation  = op;
      r.item_key   = k;
      r.item_value = v;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (op == OP_PUSH_REAR || op == OP_PUSH_FRONT) pushes_sent++;
      else pops_sent++;
   endtask

   // hold off until every outstanding response has been taken
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   function automatic logic [WORD_W-1:0] pick_key();
      if ($urandom_range(0, 9) < 7) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
      return $urandom;
   endfunction

   function automatic logic [WORD_W-1:0] pick_value();
      case ($urandom_range(0, 15))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return '0;
         3:       return '1;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [1:0] pick_op();
      if ($urandom_range(0, 99) < push_bias)
         return $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_REAR;
      return $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_REAR;
   endfunction

   initial begin
      key_pool[0] = 32'h8000_0000;
      key_pool[1] = 32'h7fff_ffff;
      key_pool[2] = '0;
      key_pool[3] = '1;
      for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // pops from an empty deque, then extremes of key and value
      send_item(OP_POP_FRONT, 32'h1234_5678, 32'h9abc_def0);
      send_item(OP_POP_REAR, '1, '1);
      send_item(OP_PUSH_REAR, 32'h7fff_ffff, 32'h8000_0000);
      send_item(OP_PUSH_FRONT, 32'h8000_0000, 32'h7fff_ffff);
      send_item(OP_PUSH_REAR, 32'h8000_0000, 32'h5555_5555);
      send_item(OP_PUSH_FRONT, 32'h7fff_ffff, 32'haaaa_aaaa);
      send_item(OP_POP_REAR, '0, '0);
      send_item(OP_POP_FRONT, '0, '0);
      // fill to capacity from both ends
      for (int i = 0; i < KDQ_CAPACITY; i++)
         send_item(i[0] ? OP_PUSH_FRONT : OP_PUSH_REAR, key_pool[i], pick_value());
      send_item(OP_PUSH_REAR, 32'h0bad_cafe, 32'h1111_1111);
      // duplicate is reported even though the deque is full
      send_item(OP_PUSH_FRONT, key_pool[5], 32'h2222_2222);
      wait_drained();

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct <= (phase == 0) ? 19 : (phase == 1) ? 79 : 0;
         recv_idle_pct <= (phase == 0) ? 79 : (phase == 1) ? 19 : 0;
         for (int n = 0; n < RANDOM_ITEMS / 3; n++) begin
            // alternate fill-heavy and drain-heavy stretches to hit full and empty
            if (n % 30 == 0) push_bias = (push_bias > 50) ? 25 : 80;
            if (phase == 1 && n == RANDOM_ITEMS / 6) wait_drained();
            send_item(pick_op(), pick_key(), pick_value());
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (2 * KDQ_CAPACITY + 8) @(posedge clock);

      $display("Sent %0d pushes and %0d pops over three pacing phases",
               pushes_sent, pops_sent);
      $display("Responses with duplicate %0d, full %0d, empty %0d",
               dup_seen, full_seen, empty_seen);
      if (fail_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
